// ----- hw/rtl/mofp_pkg.sv -----
// ----------------------------------------------------------------------------
// mofp_pkg
// Shared default widths and configuration register indexes for the
// metric-orthogonal field projection pipeline.
// ----------------------------------------------------------------------------
package mofp_pkg;

    localparam int FracBitsDefault   = 16;
    localparam int ValueWidthDefault = 32;

    // Configuration register indexes.
    localparam logic CfgRollback = 1'b0;
    localparam logic CfgDg       = 1'b1;

endpackage

// ----- hw/rtl/mofp_fmul.sv -----
// ----------------------------------------------------------------------------
// mofp_fmul
// Registered fixed-point multiply: round half up, shift by the fraction
// width and saturate to the value width.
// ----------------------------------------------------------------------------
module mofp_fmul #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    output logic signed [VALUE_WIDTH-1:0] p
);
    localparam int PW = 2 * VALUE_WIDTH + 1;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] shifted;
    logic signed [PW-1:0] maxv;
    logic signed [PW-1:0] minv;

    // Multiply stage.
    assign prod_next = PW'(a * b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    // Round, shift and saturate.
    assign shifted = (prod_reg + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign maxv = (PW'(1) <<< (VALUE_WIDTH - 1)) - PW'(1);
    assign minv = -(PW'(1) <<< (VALUE_WIDTH - 1));

    always_comb begin
        if (shifted > maxv) begin
            p = maxv[VALUE_WIDTH-1:0];
        end else if (shifted < minv) begin
            p = minv[VALUE_WIDTH-1:0];
        end else begin
            p = shifted[VALUE_WIDTH-1:0];
        end
    end
endmodule

// ----- hw/rtl/mofp_sum3.sv -----
// ----------------------------------------------------------------------------
// mofp_sum3
// Exact three-term sum with saturation to the value width.
// ----------------------------------------------------------------------------
module mofp_sum3 #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    input  logic signed [VALUE_WIDTH-1:0] c,
    output logic signed [VALUE_WIDTH-1:0] s
);
    localparam int SW = VALUE_WIDTH + 2;

    logic signed [SW-1:0] full;

    assign full = SW'(a) + SW'(b) + SW'(c);

    // Saturate when the top bits disagree with the sign.
    always_comb begin
        if (full > SW'((SW'(1) <<< (VALUE_WIDTH - 1)) - SW'(1))) begin
            s = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else if (full < -(SW'(1) <<< (VALUE_WIDTH - 1))) begin
            s = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            s = full[VALUE_WIDTH-1:0];
        end
    end
endmodule

// ----- hw/rtl/mofp_div.sv -----
// ----------------------------------------------------------------------------
// mofp_div
// Pipelined signed divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero, one quotient bit per stage, saturated to the value width. Carries
// a sideband word alongside the data.
// ----------------------------------------------------------------------------
module mofp_div #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int SIDE_W      = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [VALUE_WIDTH-1:0] num,
    input  logic signed [VALUE_WIDTH-1:0] den,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic signed [VALUE_WIDTH-1:0] quo,
    output logic [SIDE_W-1:0]             side_out
);
    // Quotient width that covers every magnitude plus one saturation bit.
    localparam int NW = VALUE_WIDTH + FRAC_BITS;
    localparam int DW = VALUE_WIDTH + 1;

    logic [NW-1:0] n_reg   [NW+1];
    logic [DW:0]   rem_reg [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic          neg_reg [NW+1];
    logic          v_reg   [NW+1];
    logic [SIDE_W-1:0] side_reg [NW+1];

    logic [DW-1:0] num_mag;
    logic [DW-1:0] den_mag;

    assign num_mag = num[VALUE_WIDTH-1] ? DW'(-DW'(num)) : DW'(num);
    assign den_mag = den[VALUE_WIDTH-1] ? DW'(-DW'(den)) : DW'(den);

    // Stage zero loads the shifted numerator magnitude.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= NW'({num_mag, {FRAC_BITS{1'b0}}});
            rem_reg[0]  <= '0;
            d_reg[0]    <= den_mag;
            neg_reg[0]  <= num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1];
            side_reg[0] <= side_in;
        end
    end

    // One restoring step per stage.
    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DW:0] trial;
        assign trial = {rem_reg[k][DW-1:0], n_reg[k][NW-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (trial >= {1'b0, d_reg[k]}) begin
                    rem_reg[k+1] <= trial - {1'b0, d_reg[k]};
                    n_reg[k+1]   <= {n_reg[k][NW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= trial;
                    n_reg[k+1]   <= {n_reg[k][NW-2:0], 1'b0};
                end
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Sign and saturate the magnitude quotient.
    logic [NW:0] qmag;
    assign qmag = {1'b0, n_reg[NW]};

    always_comb begin
        if (neg_reg[NW]) begin
            if (qmag > (NW+1)'(1) << (VALUE_WIDTH - 1)) begin
                quo = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            end else begin
                quo = VALUE_WIDTH'(-qmag);
            end
        end else begin
            if (qmag > ((NW+1)'(1) << (VALUE_WIDTH - 1)) - (NW+1)'(1)) begin
                quo = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            end else begin
                quo = qmag[VALUE_WIDTH-1:0];
            end
        end
    end

    assign out_valid = v_reg[NW];
    assign side_out  = side_reg[NW];
endmodule

// ----- hw/rtl/metric_orthogonal_field_projection_top.sv -----
// ----------------------------------------------------------------------------
// metric_orthogonal_field_projection_top
// Removes the part of E along B under a spatial metric g while projection
// is enabled, one grid point per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_axis carries E, B and six metric components;
// each output beat on m_axis carries the projected E and a flag that B.B was
// zero while projection was enabled. Two configuration registers
// (rollback_done, active_grid_is_dg) are written over cfg_*; projection runs
// when either is set. Throughput is one beat per cycle while the receiver
// does not stall. The pipeline depth is set by the pipelined divider, one
// quotient bit per stage, plus the three multiply-and-sum rounds. A
// synchronous low aresetn clears all valid bits and both registers. When the
// receiver stalls, the whole pipeline holds; s_axis_tready follows
// m_axis_tready or an empty output slot, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module metric_orthogonal_field_projection_top #(
    parameter int FRAC_BITS   = mofp_pkg::FracBitsDefault,
    parameter int VALUE_WIDTH = mofp_pkg::ValueWidthDefault
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // e_x, e_y, e_z, b_x, b_y, b_z, g_xx, g_xy, g_xz, g_yy, g_yz, g_zz
    input  logic [12*VALUE_WIDTH-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // proj_x, proj_y, proj_z, then b_norm_zero, zero padding to whole bytes
    output logic [((3*VALUE_WIDTH+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic                      cfg_data
);
    import mofp_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int OW = ((3*VALUE_WIDTH+1+7)/8)*8;
    localparam int SW = 3*W + 3*W + 2;

    typedef logic signed [W-1:0] val_t;

    logic rollback_reg;
    logic dg_reg;
    logic en;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rollback_reg <= 1'b0;
            dg_reg       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CfgRollback: rollback_reg <= cfg_data;
                CfgDg:       dg_reg       <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Global pipeline enable: advance when the output slot is free or taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    val_t e_in [3];
    val_t b_in [3];
    val_t g_in [6];
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign e_in[i] = s_axis_tdata[i*W +: W];
        assign b_in[i] = s_axis_tdata[(3+i)*W +: W];
    end
    for (genvar i = 0; i < 6; i++) begin : g_unpack_g
        assign g_in[i] = s_axis_tdata[(6+i)*W +: W];
    end

    // Stage A: register the input beat.
    logic a_v_reg;
    logic a_on_reg;
    val_t a_e_reg [3];
    val_t a_b_reg [3];
    val_t a_g_reg [6];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_axis_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            a_e_reg  <= e_in;
            a_b_reg  <= b_in;
            a_g_reg  <= g_in;
            a_on_reg <= rollback_reg | dg_reg;
        end
    end

    // Stage B: nine metric products g_ij * B_j.
    val_t gb [3][3];
    val_t gsel [3][3];
    assign gsel[0][0] = a_g_reg[0];
    assign gsel[0][1] = a_g_reg[1];
    assign gsel[0][2] = a_g_reg[2];
    assign gsel[1][0] = a_g_reg[1];
    assign gsel[1][1] = a_g_reg[3];
    assign gsel[1][2] = a_g_reg[4];
    assign gsel[2][0] = a_g_reg[2];
    assign gsel[2][1] = a_g_reg[4];
    assign gsel[2][2] = a_g_reg[5];
    for (genvar i = 0; i < 3; i++) begin : g_gb_i
        for (genvar j = 0; j < 3; j++) begin : g_gb_j
            mofp_fmul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(W)) u_mul (
                .aclk(aclk), .en(en), .a(gsel[i][j]), .b(a_b_reg[j]), .p(gb[i][j])
            );
        end
    end

    logic b_v_reg;
    logic b_on_reg;
    val_t b_e_reg [3];
    val_t b_b_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            b_e_reg  <= a_e_reg;
            b_b_reg  <= a_b_reg;
            b_on_reg <= a_on_reg;
        end
    end

    // Stage C: lowered field w_i.
    val_t w_sum [3];
    val_t c_w_reg [3];
    val_t c_e_reg [3];
    val_t c_b_reg [3];
    logic c_v_reg;
    logic c_on_reg;
    for (genvar i = 0; i < 3; i++) begin : g_w
        mofp_sum3 #(.VALUE_WIDTH(W)) u_sum (
            .a(gb[i][0]), .b(gb[i][1]), .c(gb[i][2]), .s(w_sum[i])
        );
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= b_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c_w_reg  <= w_sum;
            c_e_reg  <= b_e_reg;
            c_b_reg  <= b_b_reg;
            c_on_reg <= b_on_reg;
        end
    end

    // Stage D: products for B.B and E.B.
    val_t bw [3];
    val_t ew [3];
    for (genvar i = 0; i < 3; i++) begin : g_dot
        mofp_fmul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(W)) u_bw (
            .aclk(aclk), .en(en), .a(c_b_reg[i]), .b(c_w_reg[i]), .p(bw[i])
        );
        mofp_fmul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(W)) u_ew (
            .aclk(aclk), .en(en), .a(c_e_reg[i]), .b(c_w_reg[i]), .p(ew[i])
        );
    end
    logic d_v_reg;
    logic d_on_reg;
    val_t d_e_reg [3];
    val_t d_b_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg <= c_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            d_e_reg  <= c_e_reg;
            d_b_reg  <= c_b_reg;
            d_on_reg <= c_on_reg;
        end
    end

    // Stage E: dot-product sums and the zero check.
    val_t bb;
    val_t eb;
    mofp_sum3 #(.VALUE_WIDTH(W)) u_bb (.a(bw[0]), .b(bw[1]), .c(bw[2]), .s(bb));
    mofp_sum3 #(.VALUE_WIDTH(W)) u_eb (.a(ew[0]), .b(ew[1]), .c(ew[2]), .s(eb));

    logic e_v_reg;
    val_t e_bb_reg;
    val_t e_eb_reg;
    val_t e_e_reg [3];
    val_t e_b_reg [3];
    logic e_on_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_v_reg <= 1'b0;
        end else if (en) begin
            e_v_reg <= d_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            e_bb_reg <= bb;
            e_eb_reg <= eb;
            e_e_reg  <= d_e_reg;
            e_b_reg  <= d_b_reg;
            e_on_reg <= d_on_reg;
        end
    end

    // Divider: ratio = E.B * 2^FRAC_BITS / B.B. Zero divisor is harmless here.
    logic [SW-1:0] side_in;
    logic [SW-1:0] side_out;
    logic          q_v;
    val_t          ratio;
    logic          bb_zero;
    assign bb_zero = (e_bb_reg == '0);
    assign side_in = {e_on_reg, bb_zero,
                      e_b_reg[2], e_b_reg[1], e_b_reg[0],
                      e_e_reg[2], e_e_reg[1], e_e_reg[0]};

    mofp_div #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(W), .SIDE_W(SW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(e_v_reg),
        .num(e_eb_reg), .den(e_bb_reg), .side_in(side_in),
        .out_valid(q_v), .quo(ratio), .side_out(side_out)
    );

    val_t f_e [3];
    val_t f_b [3];
    logic f_on;
    logic f_zero;
    for (genvar i = 0; i < 3; i++) begin : g_side
        assign f_e[i] = side_out[i*W +: W];
        assign f_b[i] = side_out[(3+i)*W +: W];
    end
    assign f_zero = side_out[6*W];
    assign f_on   = side_out[6*W+1];

    // Stage F: ratio * B_d.
    val_t rb [3];
    for (genvar i = 0; i < 3; i++) begin : g_rb
        mofp_fmul #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(W)) u_rb (
            .aclk(aclk), .en(en), .a(ratio), .b(f_b[i]), .p(rb[i])
        );
    end
    logic g_v_reg;
    logic g_on_reg;
    logic g_zero_reg;
    val_t g_e_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_v_reg <= 1'b0;
        end else if (en) begin
            g_v_reg <= q_v;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            g_e_reg    <= f_e;
            g_on_reg   <= f_on;
            g_zero_reg <= f_zero;
        end
    end

    // Stage G: E - ratio * B saturated, or E if off or B.B zero; output reg.
    val_t proj [3];
    val_t neg_rb [3];
    for (genvar i = 0; i < 3; i++) begin : g_proj
        logic signed [W+1:0] diff;
        assign diff = (W+2)'(g_e_reg[i]) - (W+2)'(rb[i]);
        always_comb begin
            if (!g_on_reg || g_zero_reg) begin
                proj[i] = g_e_reg[i];
            end else if (diff > (W+2)'((W+2)'(1) <<< (W - 1)) - (W+2)'(1)) begin
                proj[i] = {1'b0, {(W-1){1'b1}}};
            end else if (diff < -((W+2)'(1) <<< (W - 1))) begin
                proj[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                proj[i] = diff[W-1:0];
            end
        end
        assign neg_rb[i] = rb[i];
    end

    logic          out_v_reg;
    logic [OW-1:0] out_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= g_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_d_reg <= OW'({g_on_reg & g_zero_reg, proj[2], proj[1], neg_rb[0] ^ neg_rb[0]
                              ^ proj[0]});
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;
endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Metric-orthogonal field projection testbench
// Streams grid points through the block under several settings of the two
// projection enables and checks every output beat against a bit-exact
// fixed-point predictor, with random gaps on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module testbench;
    import mofp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FracBitsDefault;
    localparam int VW = ValueWidthDefault;
    localparam int OW = ((3 * VW + 1 + 7) / 8) * 8;
    localparam int LATENCY = 8 + VW + FB;

    typedef logic signed [VW-1:0] fix_t;

    // Fields from the top bit down, so proj_x sits in the lowest bits.
    typedef struct packed {
        logic       zero_norm;
        fix_t       pz;
        fix_t       py;
        fix_t       px;
    } projection_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [12*VW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic cfg_data = 1'b0;

    logic rollback_reg = 1'b0;
    logic dg_reg = 1'b0;
    projection_t projection_queue[$];
    int mismatches = 0;
    int points_sent = 0;
    int points_checked = 0;
    int flagged_points = 0;
    int stall_mode = 0;

    metric_orthogonal_field_projection_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Saturate a wide signed value to the value width.
    function automatic fix_t clamp(input logic signed [191:0] v);
        logic signed [191:0] hi;
        logic signed [191:0] lo;
        hi = (192'sd1 <<< (VW - 1)) - 1;
        lo = -(192'sd1 <<< (VW - 1));
        if (v > hi) return hi[VW-1:0];
        if (v < lo) return lo[VW-1:0];
        return v[VW-1:0];
    endfunction

    // Fixed-point product, rounded half up, saturated.
    function automatic fix_t fix_mul(input fix_t a, input fix_t b);
        logic signed [191:0] p;
        p = 192'(a) * 192'(b);
        p = (p + (192'sd1 <<< (FB - 1))) >>> FB;
        return clamp(p);
    endfunction

    function automatic fix_t fix_sum3(input fix_t a, input fix_t b, input fix_t c);
        return clamp(192'(a) + 192'(b) + 192'(c));
    endfunction

    // Projection of E off B under the metric; fields in beat order.
    function automatic projection_t project_point(input logic [12*VW-1:0] pt);
        fix_t e[3];
        fix_t b[3];
        fix_t g[3][3];
        fix_t w[3];
        fix_t bb;
        fix_t eb;
        fix_t ratio;
        fix_t res[3];
        logic signed [191:0] num;
        logic signed [191:0] q;
        projection_t r;
        for (int i = 0; i < 3; i++) begin
            e[i] = pt[i*VW +: VW];
            b[i] = pt[(3+i)*VW +: VW];
            res[i] = e[i];
        end
        g[0][0] = pt[6*VW +: VW];
        g[0][1] = pt[7*VW +: VW];
        g[0][2] = pt[8*VW +: VW];
        g[1][1] = pt[9*VW +: VW];
        g[1][2] = pt[10*VW +: VW];
        g[2][2] = pt[11*VW +: VW];
        g[1][0] = g[0][1];
        g[2][0] = g[0][2];
        g[2][1] = g[1][2];
        r.zero_norm = 1'b0;
        if (rollback_reg || dg_reg) begin
            for (int i = 0; i < 3; i++)
                w[i] = fix_sum3(fix_mul(g[i][0], b[0]), fix_mul(g[i][1], b[1]),
                                fix_mul(g[i][2], b[2]));
            bb = fix_sum3(fix_mul(b[0], w[0]), fix_mul(b[1], w[1]), fix_mul(b[2], w[2]));
            eb = fix_sum3(fix_mul(e[0], w[0]), fix_mul(e[1], w[1]), fix_mul(e[2], w[2]));
            if (bb == 0) begin
                r.zero_norm = 1'b1;
            end else begin
                // Signed division truncates toward zero in SystemVerilog.
                num = 192'(eb) <<< FB;
                q = num / 192'(bb);
                ratio = clamp(q);
                for (int i = 0; i < 3; i++)
                    res[i] = clamp(192'(e[i]) - 192'(fix_mul(ratio, b[i])));
            end
        end
        r.px = res[0];
        r.py = res[1];
        r.pz = res[2];
        return r;
    endfunction

    // Receiver stall pattern, changed per phase.
    always @(posedge aclk) begin
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) < 2);
            end
        endcase
    end

    // Output beat checker.
    always @(posedge aclk) begin
        projection_t want;
        projection_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[3*VW:0];
            if (projection_queue.size() == 0) begin
                $error("output beat with no pending grid point");
                mismatches++;
            end else begin
                want = projection_queue.pop_front();
                points_checked++;
                if (got.zero_norm) flagged_points++;
                if (got.px !== want.px) begin
                    $error("proj_x: expected %0d, got %0d", want.px, got.px);
                    mismatches++;
                end
                if (got.py !== want.py) begin
                    $error("proj_y: expected %0d, got %0d", want.py, got.py);
                    mismatches++;
                end
                if (got.pz !== want.pz) begin
                    $error("proj_z: expected %0d, got %0d", want.pz, got.pz);
                    mismatches++;
                end
                if (got.zero_norm !== want.zero_norm) begin
                    $error("b_norm_zero: expected %0d, got %0d",
                           want.zero_norm, got.zero_norm);
                    mismatches++;
                end
            end
        end
    end

    // Write one enable register while the pipeline is idle.
    task automatic write_reg(input logic idx, input logic val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CfgRollback) rollback_reg = val;
        else dg_reg = val;
        @(posedge aclk);
    endtask

    task automatic set_enables(input logic rb, input logic dg);
        write_reg(CfgRollback, rb);
        write_reg(CfgDg, dg);
    endtask

    // Send one grid point, holding valid between back-to-back beats.
    task automatic send_point(input logic [12*VW-1:0] pt, input bit hold);
        s_axis_tdata <= pt;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        projection_queue.push_back(project_point(pt));
        points_sent++;
        if (!hold) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (projection_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic fix_t rand_fix(input int kind);
        case (kind)
            0: return fix_t'($urandom);
            1: return fix_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return fix_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return $urandom_range(0, 1) ? {1'b0, {(VW-1){1'b1}}}
                                                  : {1'b1, {(VW-1){1'b0}}};
        endcase
    endfunction

    // Random grid point: mostly physical-scale values, some diagonal metrics.
    function automatic logic [12*VW-1:0] random_point();
        logic [12*VW-1:0] pt;
        int kind;
        kind = $urandom_range(0, 9);
        for (int f = 0; f < 12; f++) begin
            if (kind == 0) pt[f*VW +: VW] = rand_fix(0);
            else if (kind == 1) pt[f*VW +: VW] = rand_fix($urandom_range(0, 3));
            else pt[f*VW +: VW] = rand_fix($urandom_range(1, 2));
        end
        // Identity-like metric or zero B now and then.
        if (kind == 2) begin
            pt[6*VW +: VW] = 1 << FB;
            pt[9*VW +: VW] = 1 << FB;
            pt[11*VW +: VW] = 1 << FB;
            pt[7*VW +: VW] = '0;
            pt[8*VW +: VW] = '0;
            pt[10*VW +: VW] = '0;
        end
        if (kind == 3) pt[3*VW +: 3*VW] = '0;
        return pt;
    endfunction

    function automatic logic [12*VW-1:0] uniform_point(input fix_t v);
        logic [12*VW-1:0] pt;
        for (int f = 0; f < 12; f++) pt[f*VW +: VW] = v;
        return pt;
    endfunction

    task automatic test_directed();
        logic [12*VW-1:0] pt;
        fix_t maxv;
        fix_t minv;
        maxv = {1'b0, {(VW-1){1'b1}}};
        minv = {1'b1, {(VW-1){1'b0}}};
        stall_mode = 0;
        set_enables(1'b0, 1'b1);
        send_point(uniform_point('0), 0);
        send_point(uniform_point(maxv), 0);
        send_point(uniform_point(minv), 0);
        send_point(uniform_point('1), 0);
        send_point(uniform_point(1 << FB), 0);
        // E along B with a unit metric: projection gives zero.
        pt = random_point();
        pt[0 +: 3*VW] = {fix_t'(3 << FB), fix_t'(2 << FB), fix_t'(1 << FB)};
        pt[3*VW +: 3*VW] = {fix_t'(3 << FB), fix_t'(2 << FB), fix_t'(1 << FB)};
        pt[6*VW +: 6*VW] = {fix_t'(1 << FB), fix_t'(0), fix_t'(1 << FB),
                            fix_t'(0), fix_t'(0), fix_t'(1 << FB)};
        send_point(pt, 0);
        // Non-definite metric gives negative B.B.
        pt[6*VW +: 6*VW] = {fix_t'(-(1 << FB)), fix_t'(0), fix_t'(-(2 << FB)),
                            fix_t'(1 << FB), fix_t'(0), fix_t'(-(1 << FB))};
        send_point(pt, 0);
        // Zero B and a zero metric give a zero norm.
        pt[3*VW +: 3*VW] = '0;
        send_point(pt, 0);
        pt = random_point();
        pt[6*VW +: 6*VW] = '0;
        send_point(pt, 0);
        // Tiny B whose norm rounds away to zero.
        pt = uniform_point(fix_t'(1));
        send_point(pt, 0);
        // Saturating ratio: large E, small B.
        pt = uniform_point(fix_t'(1 << FB));
        pt[0 +: 3*VW] = {maxv, maxv, maxv};
        pt[3*VW +: 3*VW] = {fix_t'(1 << 8), fix_t'(1 << 8), fix_t'(1 << 8)};
        send_point(pt, 0);
        drain();
        // Same extremes with projection off and with rollback.
        set_enables(1'b0, 1'b0);
        send_point(uniform_point(maxv), 0);
        send_point(random_point(), 0);
        drain();
        set_enables(1'b1, 1'b0);
        send_point(uniform_point(minv), 0);
        send_point(pt, 0);
        drain();
    endtask

    task automatic test_random_phase(input logic rb, input logic dg, input int count,
                                     input int mode);
        int left;
        int burst;
        stall_mode = mode;
        set_enables(rb, dg);
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int i = 0; i < burst; i++)
                send_point(random_point(), i != burst - 1);
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(1'b1, 1'b1, 300, 0);
        test_random_phase(1'b0, 1'b1, 300, 1);
        test_random_phase(1'b1, 1'b0, 250, 2);
        test_random_phase(1'b0, 1'b0, 250, 1);
        $display("Checked %0d of %0d grid points, %0d with zero B.B, across all",
                 points_checked, points_sent, flagged_points);
        $display("enable settings with and without output stalls.");
        if (mismatches == 0 && projection_queue.size() == 0) begin
            $display("metric_orthogonal_field_projection_top test passed");
        end else begin
            $display("metric_orthogonal_field_projection_top test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("metric_orthogonal_field_projection_top test failed");
        $finish;
    end
endmodule
